// ===== design/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the deadline task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int N_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  typedef enum logic [2:0] {
    KIND_PUSHED  = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_POPPED  = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_EXPIRED = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] added;
    logic [15:0] dl;
    logic        has_dl;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== design/dtq_cell.sv =====
// ----------------------------------------------------------------------------
// dtq_cell
// One queue slot: loads a new entry or takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     load_data,
  input  entry_t     nbr,
  output entry_t     data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= nbr;
    end
  end

endmodule

// ===== design/deadline_task_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_task_queue
// FIFO of task handles with optional deadlines, expired on time ticks.
// ----------------------------------------------------------------------------
// Input items carry cmd (push, pop, tick) with task fields; output items carry
// kind, task_id_res and last. Both channels use valid/stall.
// Push and pop: accepted when the output register is free; the
// result appears the next cycle. The next item may follow right behind.
// Tick: the seconds counter advances, then the queue rotates through the head
// cell one entry per cycle unless a stalled output holds an expiry. Up to
// MAX_RESULTS due entries are dropped and emitted in order, the others are
// reinserted behind the unscanned ones. The input is stalled from the tick
// through the scan and flush states and while the receiver stalls an expiry.
// One expiry is held back so the final one can carry last.
// The age compare at the head cell limits the unstalled scan to one entry a cycle.
// Reset empties the queue and clears the counter. A stalled output item holds
// and blocks new input until it is taken.
// ----------------------------------------------------------------------------
module deadline_task_queue import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  task_id,
  input  logic        has_deadline,
  input  logic [15:0] deadline,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  task_id_res,
  output logic        last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t          state;
  logic [CW-1:0]   occupancy;
  logic [31:0]     now_seconds;
  logic [CW-1:0]   rem;
  logic [CW-1:0]   kept;
  logic [N_W-1:0]  cnt;
  logic            pending_valid;
  logic [7:0]      pending_id;
  kind_t           kind_r;

  entry_t          cells [QUEUE_DEPTH];
  cell_ctrl_t      ctrl  [QUEUE_DEPTH];
  entry_t          load_data;

  logic            out_free;
  logic            out_load;
  logic            in_acc;
  logic            push_acc;
  logic            pop_acc;
  logic [31:0]     age;
  logic            due;
  logic            scan_emit;
  logic            scan_step;
  logic [CW-1:0]   pos;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign push_acc  = in_acc && (cmd == CMD_PUSH) && (occupancy < CW'(QUEUE_DEPTH));
  assign pop_acc   = in_acc && (cmd == CMD_POP) && (occupancy != '0);

  assign age       = now_seconds - cells[0].added;
  assign due       = cells[0].has_dl && (age >= {16'd0, cells[0].dl});
  assign scan_emit = due && (cnt < N_W'(MAX_RESULTS));
  assign scan_step = (state == ST_SCAN) && (rem != '0) &&
                     !(scan_emit && pending_valid && !out_free);
  assign pos       = rem + kept - CW'(1);

  assign out_load  = ((state == ST_IDLE) && in_acc &&
                      ((cmd == CMD_PUSH) || (cmd == CMD_POP))) ||
                     (scan_step && scan_emit && pending_valid) ||
                     ((state == ST_FLUSH) && pending_valid && out_free);

  always_comb begin
    if (state == ST_IDLE) begin
      load_data = '{task_id: task_id, added: now_seconds, dl: deadline,
                    has_dl: has_deadline};
    end else begin
      load_data = cells[0];
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign nbr = cells[i];
    end else begin : g_mid
      assign nbr = cells[i + 1];
    end
    assign ctrl[i].shift = pop_acc || scan_step;
    assign ctrl[i].load  = (push_acc && (CW'(i) == occupancy)) ||
                           (scan_step && !scan_emit && (CW'(i) == pos));
    dtq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .load_data (load_data),
      .nbr       (nbr),
      .data      (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occupancy     <= '0;
      now_seconds   <= '0;
      rem           <= '0;
      kept          <= '0;
      cnt           <= '0;
      pending_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (cmd)
              CMD_PUSH: begin
                task_id_res <= task_id;
                last        <= 1'b1;
                if (push_acc) begin
                  kind_r    <= KIND_PUSHED;
                  occupancy <= occupancy + CW'(1);
                end else begin
                  kind_r    <= KIND_FULL;
                end
              end
              CMD_POP: begin
                last      <= 1'b1;
                if (pop_acc) begin
                  kind_r      <= KIND_POPPED;
                  task_id_res <= cells[0].task_id;
                  occupancy   <= occupancy - CW'(1);
                end else begin
                  kind_r      <= KIND_EMPTY;
                  task_id_res <= 8'd0;
                end
              end
              CMD_TICK: begin
                now_seconds   <= now_seconds + 32'd1;
                rem           <= occupancy;
                kept          <= '0;
                cnt           <= '0;
                pending_valid <= 1'b0;
                state         <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rem == '0) begin
            state <= ST_FLUSH;
          end else if (scan_step) begin
            rem <= rem - CW'(1);
            if (scan_emit) begin
              if (pending_valid) begin
                kind_r      <= KIND_EXPIRED;
                task_id_res <= pending_id;
                last        <= 1'b0;
              end
              pending_valid <= 1'b1;
              pending_id    <= cells[0].task_id;
              cnt           <= cnt + N_W'(1);
            end else begin
              kept <= kept + CW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pending_valid) begin
            occupancy <= kept;
            state     <= ST_IDLE;
          end else if (out_free) begin
            kind_r        <= KIND_EXPIRED;
            task_id_res   <= pending_id;
            last          <= 1'b1;
            pending_valid <= 1'b0;
            occupancy     <= kept;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign kind = kind_r;

endmodule
